@@ hw/rtl/cswb_pkg.sv @@
// ----------------------------------------------------------------------------
// cswb_pkg
// Shared types and constants for the clock-sweep page buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package cswb_pkg;

    // default sizing
    localparam int NUM_SLOTS_DEF = 16;
    localparam int USAGE_MAX_DEF = 7;

    // configuration register
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // word field widths
    localparam int ID_W   = 16;
    localparam int SLOT_W = 4;

    // mode codes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_ALL_PINNED = 2'd1,
        STAT_NOT_FOUND  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] table_id;
        logic [ID_W-1:0] page_id;
    } tag_t;

    typedef struct packed {
        slot_t   slot;
        logic    hit;
        logic    load_needed;
        status_t status;
    } res_t;

    // slot-file update operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_HIT   = 3'd1,
        OP_REL   = 3'd2,
        OP_FILL  = 3'd3,
        OP_DECAY = 3'd4
    } op_t;

    // status of the slot under check
    typedef struct packed {
        logic valid;
        logic pinned;
        logic idle;     // usage count is zero
    } chk_t;

endpackage

`default_nettype wire

@@ hw/rtl/clock_sweep_page_buffer.sv @@
// ----------------------------------------------------------------------------
// clock_sweep_page_buffer
// Buffer-pool slot manager with clock-sweep replacement.
// ----------------------------------------------------------------------------
//
//  port group   handshake                 payload
//  ----------   -----------------------   -----------------------------------
//  request in   in_valid / in_ready       mode, table_id, page_id
//  result out   out_valid / out_ready     slot, hit, load_needed, status
//  config       cfg_we (no wait)          cfg_wdata = slots in use
//
//  lookup walks one slot per cycle over the n slots in use; a miss then
//    sweeps one slot per cycle, decaying usage, until it can fill a slot;
//    the result is then handed off and the sequencer returns to idle
//  the single slot-file update port and tag memory read port set the pace
//  reset: all slots empty and unpinned, hand at slot 0, slots in use 16
//  one word in flight; a result waiting in the output register does not
//    block acceptance of the next word, only its hand-off
//
`default_nettype none

module clock_sweep_page_buffer #(
    parameter int NUM_SLOTS = cswb_pkg::NUM_SLOTS_DEF,
    parameter int USAGE_MAX = cswb_pkg::USAGE_MAX_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [cswb_pkg::CFG_W-1:0]  cfg_wdata,
    // request channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [cswb_pkg::ID_W-1:0]   table_id,
    input  wire logic [cswb_pkg::ID_W-1:0]   page_id,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cswb_pkg::SLOT_W-1:0]      slot,
    output logic                             hit,
    output logic                             load_needed,
    output logic [1:0]                       status
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    // slots in use register
    logic [cswb_pkg::CFG_W-1:0] slots_in_use_reg;

    // result hand-off
    logic           res_valid;
    logic           res_ready;
    cswb_pkg::res_t res;
    logic           out_valid_reg, out_valid_next;
    cswb_pkg::res_t out_res_reg, out_res_next;

    // slot file connections
    logic [IDX_W-1:0] rd_idx;
    cswb_pkg::tag_t   rd_tag;
    logic [IDX_W-1:0] chk_idx;
    cswb_pkg::chk_t   chk;
    cswb_pkg::op_t    upd_op;
    logic [IDX_W-1:0] upd_idx;
    cswb_pkg::tag_t   wr_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= cswb_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            slots_in_use_reg <= cfg_wdata;
        end
    end

    // output register takes a new result once the old one is gone
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign slot        = out_res_reg.slot;
    assign hit         = out_res_reg.hit;
    assign load_needed = out_res_reg.load_needed;
    assign status      = out_res_reg.status;

    cswb_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .slots_in_use (slots_in_use_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .table_id     (table_id),
        .page_id      (page_id),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .rd_idx       (rd_idx),
        .rd_tag       (rd_tag),
        .chk_idx      (chk_idx),
        .chk          (chk),
        .upd_op       (upd_op),
        .upd_idx      (upd_idx),
        .wr_tag       (wr_tag)
    );

    cswb_slot_file #(
        .NUM_SLOTS (NUM_SLOTS),
        .USAGE_MAX (USAGE_MAX)
    ) u_slot_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_tag  (rd_tag),
        .chk_idx (chk_idx),
        .chk     (chk),
        .upd_op  (upd_op),
        .upd_idx (upd_idx),
        .wr_tag  (wr_tag)
    );

endmodule

`default_nettype wire

@@ hw/rtl/cswb_slot_file.sv @@
// ----------------------------------------------------------------------------
// cswb_slot_file
// Slot tag memory plus per-slot valid, pin and usage flops, one update a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cswb_slot_file #(
    parameter int NUM_SLOTS = cswb_pkg::NUM_SLOTS_DEF,
    parameter int USAGE_MAX = cswb_pkg::USAGE_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]  rd_idx,
    output cswb_pkg::tag_t                     rd_tag,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]  chk_idx,
    output cswb_pkg::chk_t                     chk,
    input  wire cswb_pkg::op_t                 upd_op,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]  upd_idx,
    input  wire cswb_pkg::tag_t                wr_tag
);

    localparam int UW = $clog2(USAGE_MAX + 1);
    localparam logic [UW-1:0] USAGE_TOP = UW'(USAGE_MAX);

    cswb_pkg::tag_t tag_mem [NUM_SLOTS];
    cswb_pkg::tag_t rd_tag_reg;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] pinned_reg;
    logic [UW-1:0]        usage_reg [NUM_SLOTS];

    // tag memory, registered read
    always_ff @(posedge clk)
    begin
        if (upd_op == cswb_pkg::OP_FILL)
        begin
            tag_mem[upd_idx] <= wr_tag;
        end
        rd_tag_reg <= tag_mem[rd_idx];
    end

    assign rd_tag = rd_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            pinned_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                usage_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (upd_op)
                cswb_pkg::OP_HIT:
                begin
                    pinned_reg[upd_idx] <= 1'b1;
                    if (usage_reg[upd_idx] != USAGE_TOP)
                    begin
                        usage_reg[upd_idx] <= usage_reg[upd_idx] + UW'(1);
                    end
                end
                cswb_pkg::OP_REL:
                begin
                    pinned_reg[upd_idx] <= 1'b0;
                end
                cswb_pkg::OP_FILL:
                begin
                    valid_reg[upd_idx]  <= 1'b1;
                    pinned_reg[upd_idx] <= 1'b1;
                    usage_reg[upd_idx]  <= UW'(1);
                end
                cswb_pkg::OP_DECAY:
                begin
                    if (usage_reg[upd_idx] != '0)
                    begin
                        usage_reg[upd_idx] <= usage_reg[upd_idx] - UW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign chk.valid  = valid_reg[chk_idx];
    assign chk.pinned = pinned_reg[chk_idx];
    assign chk.idle   = (usage_reg[chk_idx] == '0);

endmodule

`default_nettype wire

@@ hw/rtl/cswb_seq.sv @@
// ----------------------------------------------------------------------------
// cswb_seq
// Sequencer: slot-by-slot lookup, then clock sweep on a request miss.
// ----------------------------------------------------------------------------
`default_nettype none

module cswb_seq #(
    parameter int NUM_SLOTS = cswb_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [cswb_pkg::CFG_W-1:0]    slots_in_use,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [cswb_pkg::ID_W-1:0]     table_id,
    input  wire logic [cswb_pkg::ID_W-1:0]     page_id,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output cswb_pkg::res_t                     res,
    output logic [$clog2(NUM_SLOTS)-1:0]       rd_idx,
    input  wire cswb_pkg::tag_t                rd_tag,
    output logic [$clog2(NUM_SLOTS)-1:0]       chk_idx,
    input  wire cswb_pkg::chk_t                chk,
    output cswb_pkg::op_t                      upd_op,
    output logic [$clog2(NUM_SLOTS)-1:0]       upd_idx,
    output cswb_pkg::tag_t                     wr_tag
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = ($clog2(NUM_SLOTS + 1) > cswb_pkg::CFG_W) ?
                           $clog2(NUM_SLOTS + 1) : cswb_pkg::CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic           mode_reg, mode_next;
    cswb_pkg::tag_t tag_reg, tag_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic           cmp_vld_reg;
    logic           unp_reg, unp_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    cswb_pkg::res_t res_reg, res_next;

    logic [CNT_W-1:0] cnt_ext;
    logic [CNT_W-1:0] eff;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] idx_wrap;
    logic             match;

    // effective slot count, clamped to 1..NUM_SLOTS
    assign cnt_ext = CNT_W'(slots_in_use);
    assign eff     = (cnt_ext == '0) ? CNT_W'(1) :
                     ((cnt_ext > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : cnt_ext);
    assign last    = IDX_W'(eff - CNT_W'(1));
    assign idx_wrap = (idx_reg == last) ? '0 : idx_reg + IDX_W'(1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;
    assign rd_idx    = idx_reg;
    assign chk_idx   = (state_reg == ST_SWEEP) ? idx_reg : cmp_idx_reg;
    assign wr_tag    = tag_reg;
    assign match     = chk.valid && (rd_tag == tag_reg);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        tag_next   = tag_reg;
        idx_next   = idx_reg;
        unp_next   = unp_reg;
        hand_next  = hand_reg;
        res_next   = res_reg;
        upd_op     = cswb_pkg::OP_NONE;
        upd_idx    = cmp_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next           = mode;
                    tag_next.table_id   = table_id;
                    tag_next.page_id    = page_id;
                    idx_next            = '0;
                    unp_next            = 1'b0;
                    state_next          = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (idx_reg != last)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    unp_next = unp_reg | ~chk.pinned;
                    if (match)
                    begin
                        res_next.slot        = cswb_pkg::slot_t'(cmp_idx_reg);
                        res_next.load_needed = 1'b0;
                        res_next.status      = cswb_pkg::STAT_OK;
                        if (mode_reg == cswb_pkg::MODE_RELEASE)
                        begin
                            upd_op       = cswb_pkg::OP_REL;
                            res_next.hit = 1'b0;
                        end
                        else
                        begin
                            upd_op       = cswb_pkg::OP_HIT;
                            res_next.hit = 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                    else if (cmp_idx_reg == last)
                    begin
                        res_next.slot        = '0;
                        res_next.hit         = 1'b0;
                        res_next.load_needed = 1'b0;
                        if (mode_reg == cswb_pkg::MODE_RELEASE)
                        begin
                            res_next.status = cswb_pkg::STAT_NOT_FOUND;
                            state_next      = ST_EMIT;
                        end
                        else if (!(unp_reg || !chk.pinned))
                        begin
                            res_next.status = cswb_pkg::STAT_ALL_PINNED;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            // hand past a shrunk slot count restarts at zero
                            idx_next   = (CNT_W'(hand_reg) < eff) ? hand_reg : '0;
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                upd_idx = idx_reg;
                if (!chk.pinned && chk.idle)
                begin
                    upd_op               = cswb_pkg::OP_FILL;
                    hand_next            = idx_wrap;
                    res_next.slot        = cswb_pkg::slot_t'(idx_reg);
                    res_next.hit         = 1'b0;
                    res_next.load_needed = 1'b1;
                    res_next.status      = cswb_pkg::STAT_OK;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    upd_op   = cswb_pkg::OP_DECAY;
                    idx_next = idx_wrap;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            hand_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_LOOK);
            hand_reg    <= hand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        tag_reg     <= tag_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= idx_reg;
        unp_reg     <= unp_next;
        res_reg     <= res_next;
    end

    // a hit never asks for a load and is always ok
    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.hit) |-> (!res.load_needed && res.status == cswb_pkg::STAT_OK))
        else $error("hit word carries load or error status");

    // an accepted word always starts a lookup
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOOK))
        else $error("accepted word did not start lookup");

    // the sweep only fills or decays
    a_sweep_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |->
            (upd_op == cswb_pkg::OP_FILL || upd_op == cswb_pkg::OP_DECAY))
        else $error("bad slot update during sweep");

    // a fill always reports a load and moves the hand past the slot
    a_fill_hand: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_op == cswb_pkg::OP_FILL) |=>
            (res_valid && res.load_needed && hand_reg == $past(idx_wrap)))
        else $error("fill without load flag or hand update");

endmodule

`default_nettype wire
